>>> sv/rrst_pkg.sv
// Package for the request/reply session tracker.
// Holds command and status codes, the phase codes and the walker state type; no dependencies.
`default_nettype none
package rrst_pkg;
  localparam logic [2:0] CMD_OPEN = 3'd0;
  localparam logic [2:0] CMD_ACK = 3'd1;
  localparam logic [2:0] CMD_RBEGIN = 3'd2;
  localparam logic [2:0] CMD_REND = 3'd3;
  localparam logic [2:0] CMD_SCAN = 3'd4;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SEND_FAIL = 4'd1;
  localparam logic [3:0] ST_MISSING = 4'd2;
  localparam logic [3:0] ST_NONE = 4'd3;
  localparam logic [3:0] ST_OPENED = 4'd4;
  localparam logic [3:0] ST_FULL = 4'd5;
  localparam logic [3:0] ST_UNKNOWN = 4'd6;
  localparam logic [3:0] ST_ACCEPTED = 4'd7;
  localparam logic [3:0] ST_SCAN_DONE = 4'd8;

  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_WAIT_ACK = 2'd1;
  localparam logic [1:0] PH_WAIT_REPLY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_OUT  = 4'b0100,
    S_LAST = 4'b1000
  } state_e;
endpackage
`default_nettype wire

>>> sv/request_reply_session_tracker_top.sv
// Top level of the request/reply session tracker.
// Uses rrst_pkg; holds the slot table, the slot walker and the output register.
//
// Usage: commands enter on the s_axis channel, one transfer per command.
// Results leave on the m_axis channel; tlast marks the final result of a command.
// Every defined command walks the slot table one slot per cycle (a scan holds while
// the receiver stalls) through a single compare and add unit, and that walk sets the
// timing. A scan visits all MAX_SESSIONS slots, then leaves the walk and sends the
// final result; open, ack and reply commands stop at the slot they hit.
// A reported result does not hold the walk while the receiver keeps up.
// A scan gives one result per reported finished session, then a scan done result.
// s_axis_tready is low while a command is being worked on.
// When the receiver stalls, the walk holds at a pending result until it is taken.
// Reset clears all slot valid bits, the time and the id counter; the table itself
// is not cleared, since open writes every entry field first.
// Undefined commands give no result.
`default_nettype none
module request_reply_session_tracker_top
  import rrst_pkg::*;
#(
  parameter int MAX_SESSIONS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cmd[2:0], cast_multicast[3], expected_replies[11:4], reply_timeout_ms[43:12],
  // com_tag[75:44], session_id[107:76], send_ok[108], elapsed_ms[124:109], zeros
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[3:0], result_session_id[35:4], result_com_tag[67:36], reply_count[75:68]
  output logic [79:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  localparam int IW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CW = $clog2(MAX_SESSIONS + 1);

  state_e state_q;
  logic [127:0] in_q;
  logic [CW-1:0] idx_q;
  logic found_q;
  logic [IW-1:0] hit_q;
  logic [31:0] now_q, id_q;
  logic [MAX_SESSIONS-1:0] valid_q;
  logic [1:0] phase_q [MAX_SESSIONS];
  logic mc_q [MAX_SESSIONS];
  logic aseen_q [MAX_SESSIONS];
  logic agood_q [MAX_SESSIONS];
  logic [7:0] exp_q [MAX_SESSIONS];
  logic [7:0] rcv_q [MAX_SESSIONS];
  logic recv_q [MAX_SESSIONS];
  logic [31:0] dl_q [MAX_SESSIONS];
  logic [31:0] wt_q [MAX_SESSIONS];
  logic [31:0] sid_q [MAX_SESSIONS];
  logic [31:0] tag_q [MAX_SESSIONS];

  logic [2:0] cmd;
  logic [31:0] in_sid;
  logic [IW-1:0] ix;
  logic in_range;
  assign cmd = in_q[2:0];
  assign in_sid = in_q[107:76];
  assign ix = idx_q[IW-1:0];
  assign in_range = (idx_q < CW'(MAX_SESSIONS));
  assign s_axis_tready = (state_q == S_IDLE);

  // Step of the current slot during a scan.
  logic [1:0] ph;
  logic tmo, fin, rep, go_wait;
  logic [3:0] code;
  logic [31:0] dd;
  always_comb begin
    ph = phase_q[ix];
    dd = dl_q[ix] - now_q - 32'd1;
    tmo = (dd >= wt_q[ix]);
    fin = 1'b0;
    go_wait = 1'b0;
    code = ST_OK;
    if (!mc_q[ix] && ph == PH_INIT) ph = PH_WAIT_ACK;
    if (mc_q[ix] && ph == PH_INIT) begin
      go_wait = 1'b1;
    end else if (!mc_q[ix] && ph == PH_WAIT_ACK) begin
      if (aseen_q[ix]) begin
        if (agood_q[ix]) go_wait = 1'b1;
        else begin
          fin = 1'b1;
          code = ST_SEND_FAIL;
        end
      end
    end else if (ph == PH_WAIT_REPLY) begin
      if (exp_q[ix] != 8'd0) begin
        if (rcv_q[ix] >= exp_q[ix]) begin
          fin = !recv_q[ix];
        end else if (tmo && !recv_q[ix]) begin
          fin = 1'b1;
          code = (rcv_q[ix] != 8'd0) ? ST_MISSING : ST_NONE;
        end
      end else if (tmo && !recv_q[ix]) begin
        fin = 1'b1;
        code = (rcv_q[ix] != 8'd0) ? ST_OK : ST_NONE;
      end
    end
    rep = fin && (exp_q[ix] == 8'd0 || code != ST_OK);
  end

  logic out_free, scan_rep, load_out;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign scan_rep = (state_q == S_WALK) && in_range && (cmd == CMD_SCAN) &&
                    valid_q[ix] && rep;
  assign load_out = out_free && (scan_rep || state_q == S_LAST);

  logic [31:0] next_id;
  always_comb begin
    next_id = id_q + 32'd1;
    if (next_id == 32'd0) next_id = 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      now_q <= '0;
      id_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_q <= s_axis_tdata;
            idx_q <= '0;
            found_q <= 1'b0;
            if (s_axis_tdata[2:0] == CMD_SCAN)
              now_q <= now_q + {16'd0, s_axis_tdata[124:109]};
            state_q <= (s_axis_tdata[2:0] > CMD_SCAN) ? S_IDLE : S_WALK;
          end
        end
        S_WALK: begin
          if (!in_range) begin
            state_q <= S_LAST;
          end else if (cmd == CMD_SCAN) begin
            // A slot with a result to report is left untouched until it can be sent.
            if (valid_q[ix] && (!rep || out_free)) begin
              if (go_wait) begin
                dl_q[ix] <= now_q + wt_q[ix];
                phase_q[ix] <= PH_WAIT_REPLY;
              end else phase_q[ix] <= ph;
              if (fin) valid_q[ix] <= 1'b0;
            end
            if (valid_q[ix] && rep) begin
              if (out_free) begin
                m_axis_tdata <= {4'd0, rcv_q[ix], tag_q[ix], sid_q[ix], code};
                m_axis_tlast <= 1'b0;
                idx_q <= idx_q + CW'(1);
              end
            end else idx_q <= idx_q + CW'(1);
          end else if (cmd == CMD_OPEN) begin
            if (!valid_q[ix]) begin
              found_q <= 1'b1;
              hit_q <= ix;
              state_q <= S_LAST;
            end else idx_q <= idx_q + CW'(1);
          end else begin
            if (valid_q[ix] && sid_q[ix] == in_sid) begin
              found_q <= 1'b1;
              hit_q <= ix;
              state_q <= S_LAST;
            end else idx_q <= idx_q + CW'(1);
          end
        end
        S_LAST: begin
          if (out_free) begin
            m_axis_tlast <= 1'b1;
            state_q <= S_IDLE;
            priority if (cmd == CMD_SCAN) begin
              m_axis_tdata <= {44'd0, 32'd0, ST_SCAN_DONE};
            end else if (cmd == CMD_OPEN) begin
              if (!found_q) m_axis_tdata <= {44'd0, 32'd0, ST_FULL};
              else begin
                id_q <= next_id;
                valid_q[hit_q] <= 1'b1;
                phase_q[hit_q] <= PH_INIT;
                mc_q[hit_q] <= in_q[3];
                aseen_q[hit_q] <= 1'b0;
                agood_q[hit_q] <= 1'b0;
                exp_q[hit_q] <= in_q[11:4];
                rcv_q[hit_q] <= 8'd0;
                recv_q[hit_q] <= 1'b0;
                dl_q[hit_q] <= 32'd0;
                wt_q[hit_q] <= in_q[43:12];
                sid_q[hit_q] <= next_id;
                tag_q[hit_q] <= in_q[75:44];
                m_axis_tdata <= {44'd0, next_id, ST_OPENED};
              end
            end else begin
              if (!found_q) m_axis_tdata <= {44'd0, in_sid, ST_UNKNOWN};
              else begin
                m_axis_tdata <= {44'd0, in_sid, ST_ACCEPTED};
                unique case (cmd)
                  CMD_ACK: begin
                    aseen_q[hit_q] <= 1'b1;
                    agood_q[hit_q] <= in_q[108];
                  end
                  CMD_RBEGIN: recv_q[hit_q] <= 1'b1;
                  default: begin
                    recv_q[hit_q] <= 1'b0;
                    if (rcv_q[hit_q] != 8'hFF) rcv_q[hit_q] <= rcv_q[hit_q] + 8'd1;
                  end
                endcase
              end
            end
          end
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
